// ----- rtl/acdf_pkg.sv -----
// Shared types, codes and constants of the comparator digital filter unit.
`timescale 1ns / 1ps

package acdf_pkg;

  // Analog level precision (low bits of each 16-bit level field are used)
  localparam int LEVEL_BITS = 16;
  // Compare width: wide enough for the level and for the band-gap constants
  localparam int CMP_W = (LEVEL_BITS > 11) ? LEVEL_BITS : 11;

  // Ladder: level = src * mult >> LADDER_K; low range uses a rounded-up reciprocal
  localparam int LADDER_K = LEVEL_BITS + 5;
  localparam int PROD_W = LEVEL_BITS + LADDER_K;
  localparam longint unsigned LADDER_SCALE = 64'd1 << LADDER_K;
  localparam logic [LADDER_K-1:0] LADDER_LOW_MULT [16] = '{
    LADDER_K'((0 * LADDER_SCALE + 23) / 24),  LADDER_K'((1 * LADDER_SCALE + 23) / 24),
    LADDER_K'((2 * LADDER_SCALE + 23) / 24),  LADDER_K'((3 * LADDER_SCALE + 23) / 24),
    LADDER_K'((4 * LADDER_SCALE + 23) / 24),  LADDER_K'((5 * LADDER_SCALE + 23) / 24),
    LADDER_K'((6 * LADDER_SCALE + 23) / 24),  LADDER_K'((7 * LADDER_SCALE + 23) / 24),
    LADDER_K'((8 * LADDER_SCALE + 23) / 24),  LADDER_K'((9 * LADDER_SCALE + 23) / 24),
    LADDER_K'((10 * LADDER_SCALE + 23) / 24), LADDER_K'((11 * LADDER_SCALE + 23) / 24),
    LADDER_K'((12 * LADDER_SCALE + 23) / 24), LADDER_K'((13 * LADDER_SCALE + 23) / 24),
    LADDER_K'((14 * LADDER_SCALE + 23) / 24), LADDER_K'((15 * LADDER_SCALE + 23) / 24)
  };
  localparam int LADDER_HIGH_BASE = 8;

  // Band-gap levels
  localparam logic [CMP_W-1:0] BG_LEVEL_1200 = CMP_W'(1200);
  localparam logic [CMP_W-1:0] BG_LEVEL_600  = CMP_W'(600);
  localparam logic [CMP_W-1:0] BG_LEVEL_200  = CMP_W'(200);

  // Operation codes
  localparam logic [1:0] OP_EVAL  = 2'd0;
  localparam logic [1:0] OP_TICK  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // Register indexes
  localparam logic [2:0] REG_COMP_FLAGS  = 3'd0;
  localparam logic [2:0] REG_NEG_SELECT  = 3'd1;
  localparam logic [2:0] REG_EVENT_EDGE  = 3'd2;
  localparam logic [2:0] REG_REF_TAP     = 3'd3;
  localparam logic [2:0] REG_REF_FLAGS   = 3'd4;
  localparam logic [2:0] REG_BG_SELECT   = 3'd5;
  localparam logic [2:0] REG_MASK_CTRL   = 3'd6;
  localparam logic [2:0] REG_FILTER_EXP  = 3'd7;

  // comp_flags bits
  localparam int CF_ENABLE   = 0;
  localparam int CF_INVERT   = 1;
  localparam int CF_INT_POS  = 2;
  localparam int CF_STOP_IDL = 3;
  localparam int CF_FILTER   = 4;

  // ref_flags bits
  localparam int RF_LADDER_EN = 0;
  localparam int RF_LOW_RANGE = 1;
  localparam int RF_FROM_VREF = 2;
  localparam int RF_VREF_DIR  = 3;

  // Selector codes
  localparam logic [1:0] NEG_INTERNAL = 2'd3;
  localparam logic [1:0] BG_1200 = 2'd0;
  localparam logic [1:0] BG_600  = 2'd1;
  localparam logic [1:0] BG_200  = 2'd2;
  localparam logic [1:0] BG_VREF = 2'd3;
  localparam logic [1:0] EDGE_NONE = 2'd0;
  localparam logic [1:0] EDGE_RISE = 2'd1;
  localparam logic [1:0] EDGE_FALL = 2'd2;
  localparam logic [1:0] EDGE_BOTH = 2'd3;

  // Blanking control register bits
  localparam int MC_AND_A_INACT = 0;
  localparam int MC_AND_A_ACT   = 1;
  localparam int MC_AND_B_INACT = 2;
  localparam int MC_AND_B_ACT   = 3;
  localparam int MC_AND_C_INACT = 4;
  localparam int MC_AND_C_ACT   = 5;
  localparam int MC_AND_TRUE    = 6;
  localparam int MC_AND_FALSE   = 7;
  localparam int MC_OR_A_INACT  = 8;
  localparam int MC_OR_A_ACT    = 9;
  localparam int MC_OR_B_INACT  = 10;
  localparam int MC_OR_B_ACT    = 11;
  localparam int MC_OR_C_INACT  = 12;
  localparam int MC_OR_C_ACT    = 13;
  localparam int MC_FORCE_LVL   = 15;

  // Filter
  localparam logic [2:0] MATCH_PUBLISH = 3'd3;

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] positive_input;
    logic [15:0] negative_input;
    logic [15:0] vref_high;
    logic [15:0] vref_low;
    logic [15:0] avdd_level;
    logic        blank_source_a;
    logic        blank_source_b;
    logic        blank_source_c;
    logic        in_idle;
  } acdf_in_t;

  typedef struct packed {
    logic filtered_output;
    logic raw_output;
    logic event_flag;
    logic event_pulse;
    logic rising_pulse;
    logic comparator_active;
  } acdf_out_t;

endpackage

// ----- rtl/acdf_in_if.sv -----
// Input item channel: valid/ready handshake with an evaluate/tick/clear payload.
`timescale 1ns / 1ps

interface acdf_in_if import acdf_pkg::*; ();
  logic     valid;
  logic     ready;
  acdf_in_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ----- rtl/acdf_out_if.sv -----
// Result item channel: valid/ready handshake with the comparator status payload.
`timescale 1ns / 1ps

interface acdf_out_if import acdf_pkg::*; ();
  logic      valid;
  logic      ready;
  acdf_out_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ----- rtl/analog_comparator_digital_filter_unit.sv -----
// Top level: comparator channel with blanking, digital filter and event latch.
//
//  Channel   Direction  Handshake            Contents
//  in_ch     sink       valid/ready          operation, levels, blanking, idle
//  out_ch    source     valid/ready          one status result per input item
//  APB       slave      psel/penable/pready  eight config registers at 4*i
//
// One item per cycle while out_ch.ready holds; items pass the input register,
// then the compare/filter logic into the result register. The filter state
// updates as an item moves into the result register. A stalled result holds
// while one more item waits in the input register. rst_n is synchronous.
`timescale 1ns / 1ps

module analog_comparator_digital_filter_unit import acdf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  acdf_in_if.sink     in_ch,
  acdf_out_if.source  out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Configuration registers
  logic [4:0]  comp_flags_r;
  logic [1:0]  neg_select_r;
  logic [1:0]  event_edge_r;
  logic [3:0]  ref_tap_r;
  logic [3:0]  ref_flags_r;
  logic [1:0]  bg_select_r;
  logic [15:0] mask_ctrl_r;
  logic [2:0]  filter_exp_r;

  // Filter state
  logic       raw_r, filt_r, cand_r, evt_r;
  logic [1:0] match_r;
  logic [6:0] div_r;
  logic       raw_nxt, filt_nxt, cand_nxt, evt_nxt;
  logic [1:0] match_nxt;
  logic [6:0] div_nxt;

  // Pipeline registers
  logic      s1_valid_r;
  acdf_in_t  s1_data_r;
  logic      out_valid_r;
  acdf_out_t out_data_r;
  acdf_out_t result;
  logic      adv;

  logic       cfg_wr;
  logic [2:0] cfg_idx;
  logic       filt_restart;

  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = paddr[4:2];
  assign pready  = 1'b1;

  // Filter settings change: restart the divider and the agreement count
  assign filt_restart = cfg_wr &
      (((cfg_idx == REG_COMP_FLAGS) &
        ((pwdata[CF_ENABLE] != comp_flags_r[CF_ENABLE]) |
         (pwdata[CF_FILTER] != comp_flags_r[CF_FILTER]))) |
       ((cfg_idx == REG_FILTER_EXP) & (pwdata[2:0] != filter_exp_r)));

  // Register read-back
  always_comb begin
    prdata = '0;
    case (cfg_idx)
      REG_COMP_FLAGS: prdata = 32'(comp_flags_r);
      REG_NEG_SELECT: prdata = 32'(neg_select_r);
      REG_EVENT_EDGE: prdata = 32'(event_edge_r);
      REG_REF_TAP:    prdata = 32'(ref_tap_r);
      REG_REF_FLAGS:  prdata = 32'(ref_flags_r);
      REG_BG_SELECT:  prdata = 32'(bg_select_r);
      REG_MASK_CTRL:  prdata = 32'(mask_ctrl_r);
      REG_FILTER_EXP: prdata = 32'(filter_exp_r);
      default:        prdata = '0;
    endcase
  end

  // Handshake: the input register advances when the result register is free
  assign adv          = s1_valid_r & (~out_valid_r | out_ch.ready);
  assign in_ch.ready  = ~s1_valid_r | adv;
  assign out_ch.valid = out_valid_r;
  assign out_ch.payload = out_data_r;

  // Level extraction
  logic [LEVEL_BITS-1:0] pin, nin, vh, vl, avdd;
  assign pin  = s1_data_r.positive_input[LEVEL_BITS-1:0];
  assign nin  = s1_data_r.negative_input[LEVEL_BITS-1:0];
  assign vh   = s1_data_r.vref_high[LEVEL_BITS-1:0];
  assign vl   = s1_data_r.vref_low[LEVEL_BITS-1:0];
  assign avdd = s1_data_r.avdd_level[LEVEL_BITS-1:0];

  // Internal positive reference: ladder tap by one multiply (table constant in low range)
  logic                  ladder_ok, pos_ok;
  logic [LEVEL_BITS-1:0] ladder_src, ladder_level, pos_level;
  logic [LADDER_K-1:0]   ladder_mult;
  logic [PROD_W-1:0]     ladder_prod;

  always_comb begin
    ladder_ok = ref_flags_r[RF_LADDER_EN] & ~(ref_flags_r[RF_FROM_VREF] & (vh < vl));
    pos_ok = comp_flags_r[CF_INT_POS] & (ref_flags_r[RF_VREF_DIR] | ladder_ok);
    ladder_src = ref_flags_r[RF_FROM_VREF] ? (vh - vl) : avdd;
    if (ref_flags_r[RF_LOW_RANGE]) begin
      ladder_mult = LADDER_LOW_MULT[ref_tap_r];
    end else begin
      ladder_mult = LADDER_K'({1'b0, ref_tap_r} + 5'(LADDER_HIGH_BASE)) << (LADDER_K - 5);
    end
    ladder_prod  = PROD_W'(ladder_src) * PROD_W'(ladder_mult);
    ladder_level = ladder_prod[LADDER_K +: LEVEL_BITS];
    pos_level    = ref_flags_r[RF_VREF_DIR] ? vh : ladder_level;
  end

  // Internal negative level
  logic             neg_ok;
  logic [CMP_W-1:0] neg_level, pos_cmp, neg_cmp;

  always_comb begin
    neg_ok = (neg_select_r == NEG_INTERNAL) &
             ((bg_select_r != BG_VREF) | ~ref_flags_r[RF_FROM_VREF]);
    case (bg_select_r)
      BG_1200: neg_level = BG_LEVEL_1200;
      BG_600:  neg_level = BG_LEVEL_600;
      BG_200:  neg_level = BG_LEVEL_200;
      default: neg_level = CMP_W'(vh);
    endcase
    pos_cmp = pos_ok ? CMP_W'(pos_level) : CMP_W'(pin);
    neg_cmp = neg_ok ? neg_level : CMP_W'(nin);
  end

  // Setup check and activity
  logic supported, active, filt_on;
  assign supported = comp_flags_r[CF_ENABLE] &
                     ~(comp_flags_r[CF_INT_POS] & ~pos_ok) &
                     ~((neg_select_r == NEG_INTERNAL) & ~neg_ok);
  assign active  = supported & ~(s1_data_r.in_idle & comp_flags_r[CF_STOP_IDL]);
  assign filt_on = comp_flags_r[CF_FILTER];

  // Blanking AND/OR logic
  logic sa, sb, sc, blank_or, blank_and, blank;
  always_comb begin
    sa = s1_data_r.blank_source_a;
    sb = s1_data_r.blank_source_b;
    sc = s1_data_r.blank_source_c;
    blank_or = (mask_ctrl_r[MC_OR_A_ACT] & sa) | (mask_ctrl_r[MC_OR_A_INACT] & ~sa) |
               (mask_ctrl_r[MC_OR_B_ACT] & sb) | (mask_ctrl_r[MC_OR_B_INACT] & ~sb) |
               (mask_ctrl_r[MC_OR_C_ACT] & sc) | (mask_ctrl_r[MC_OR_C_INACT] & ~sc);
    blank_and = (~mask_ctrl_r[MC_AND_A_ACT] | sa) & (~mask_ctrl_r[MC_AND_A_INACT] | ~sa) &
                (~mask_ctrl_r[MC_AND_B_ACT] | sb) & (~mask_ctrl_r[MC_AND_B_INACT] | ~sb) &
                (~mask_ctrl_r[MC_AND_C_ACT] | sc) & (~mask_ctrl_r[MC_AND_C_INACT] | ~sc);
    blank = blank_or | (mask_ctrl_r[MC_AND_TRUE] & blank_and) |
            (mask_ctrl_r[MC_AND_FALSE] & ~blank_and);
  end

  logic raw_eval;
  assign raw_eval = blank ? mask_ctrl_r[MC_FORCE_LVL]
                          : ((pos_cmp > neg_cmp) ^ comp_flags_r[CF_INVERT]);

  // Filter, publish and event logic for the item in the input register
  logic       pub_en, pub_val, edge_hit, rise_pulse, evt_pulse;
  logic [7:0] div_acc, div_limit;
  logic [2:0] match_inc;

  always_comb begin
    raw_nxt   = raw_r;
    filt_nxt  = filt_r;
    cand_nxt  = cand_r;
    match_nxt = match_r;
    div_nxt   = div_r;
    evt_nxt   = evt_r;
    pub_en    = 1'b0;
    pub_val   = filt_r;
    div_acc   = {1'b0, div_r} + 8'd1;
    div_limit = 8'd1 << filter_exp_r;
    match_inc = {1'b0, match_r} + 3'd1;

    case (s1_data_r.operation)
      OP_EVAL: begin
        if (!supported) begin
          raw_nxt   = 1'b0;
          filt_nxt  = 1'b0;
          match_nxt = '0;
        end else if (active) begin
          raw_nxt = raw_eval;
          if (!filt_on) begin
            match_nxt = '0;
            pub_en    = 1'b1;
            pub_val   = raw_eval;
          end
        end
      end
      OP_TICK: begin
        if (active && filt_on) begin
          if (div_acc >= div_limit) begin
            div_nxt = '0;
            // one filter sample
            if (raw_r == filt_r) begin
              match_nxt = '0;
            end else if (match_r == 2'd0 || raw_r != cand_r) begin
              match_nxt = 2'd1;
              cand_nxt  = raw_r;
            end else if (match_inc >= MATCH_PUBLISH) begin
              match_nxt = '0;
              pub_en    = 1'b1;
              pub_val   = raw_r;
            end else begin
              match_nxt = match_inc[1:0];
            end
          end else begin
            div_nxt = div_acc[6:0];
          end
        end
      end
      OP_CLEAR: evt_nxt = 1'b0;
      default: ;
    endcase

    // Publish: rising pulse and edge event
    case (event_edge_r)
      EDGE_RISE: edge_hit = ~filt_r & pub_val;
      EDGE_FALL: edge_hit = filt_r & ~pub_val;
      EDGE_BOTH: edge_hit = filt_r ^ pub_val;
      default:   edge_hit = 1'b0;
    endcase
    rise_pulse = pub_en & ~filt_r & pub_val;
    evt_pulse  = pub_en & ~evt_r & edge_hit;
    if (pub_en) begin
      filt_nxt = pub_val;
    end
    if (evt_pulse) begin
      evt_nxt = 1'b1;
    end

    result.filtered_output   = filt_nxt;
    result.raw_output        = raw_nxt;
    result.event_flag        = evt_nxt;
    result.event_pulse       = evt_pulse;
    result.rising_pulse      = rise_pulse;
    result.comparator_active = active;
  end

  // Configuration, filter state and pipeline registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      comp_flags_r <= '0;
      neg_select_r <= '0;
      event_edge_r <= '0;
      ref_tap_r    <= '0;
      ref_flags_r  <= '0;
      bg_select_r  <= '0;
      mask_ctrl_r  <= '0;
      filter_exp_r <= '0;
      raw_r        <= 1'b0;
      filt_r       <= 1'b0;
      cand_r       <= 1'b0;
      match_r      <= '0;
      div_r        <= '0;
      evt_r        <= 1'b0;
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      // item transfer into the result register updates the filter state
      if (adv) begin
        raw_r   <= raw_nxt;
        filt_r  <= filt_nxt;
        cand_r  <= cand_nxt;
        evt_r   <= evt_nxt;
      end

      // filter settings changes restart the divider and count
      if (filt_restart) begin
        div_r   <= '0;
        match_r <= '0;
      end else if (adv) begin
        div_r   <= div_nxt;
        match_r <= match_nxt;
      end

      // register writes
      if (cfg_wr) begin
        case (cfg_idx)
          REG_COMP_FLAGS: comp_flags_r <= pwdata[4:0];
          REG_NEG_SELECT: neg_select_r <= pwdata[1:0];
          REG_EVENT_EDGE: event_edge_r <= pwdata[1:0];
          REG_REF_TAP:    ref_tap_r    <= pwdata[3:0];
          REG_REF_FLAGS:  ref_flags_r  <= pwdata[3:0];
          REG_BG_SELECT:  bg_select_r  <= pwdata[1:0];
          REG_MASK_CTRL:  mask_ctrl_r  <= pwdata[15:0];
          REG_FILTER_EXP: filter_exp_r <= pwdata[2:0];
          default: ;
        endcase
      end

      // input register
      if (in_ch.valid && in_ch.ready) begin
        s1_valid_r <= 1'b1;
      end else if (adv) begin
        s1_valid_r <= 1'b0;
      end

      // result register
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_data_r <= in_ch.payload;
    end
    if (adv) begin
      out_data_r <= result;
    end
  end

endmodule

// ----- sim/comparator_filter_checker.sv -----
// Passive checker: mirrors the register file, predicts each status result and compares.
`timescale 1ns / 1ps

module comparator_filter_checker import acdf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  acdf_in_if          in_bus,
  acdf_out_if         out_bus,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic [31:0] prdata,
  input  logic        pready,
  output int          mismatches,
  output int          outstanding,
  output int          items_seen,
  output int          results_seen,
  output int          events_seen,
  output int          rises_seen
);

  // Register mirror
  logic [4:0]  comp_flags_q;
  logic [1:0]  neg_sel_q;
  logic [1:0]  edge_sel_q;
  logic [3:0]  tap_q;
  logic [3:0]  ref_flags_q;
  logic [1:0]  bg_sel_q;
  logic [15:0] mask_q;
  logic [2:0]  div_exp_q;

  // Comparator and filter state
  logic       raw_q;
  logic       published_q;
  logic       candidate_q;
  logic       latched_q;
  logic [1:0] agree_cnt;
  logic [6:0] tick_cnt;
  logic       event_now;
  logic       rise_now;

  acdf_out_t status_queue[$];
  int errs = 0;
  int n_items = 0;
  int n_results = 0;
  int n_events = 0;
  int n_rises = 0;

  function automatic int unsigned trim_level(logic [15:0] v);
    return int'(v) & ((32'd1 << LEVEL_BITS) - 1);
  endfunction

  // Ladder or VREF+ on the positive side; 0 when that source is unavailable
  function automatic bit positive_ref(acdf_in_t it, output int unsigned level);
    int unsigned src, vh, vl;
    level = 0;
    vh = trim_level(it.vref_high);
    vl = trim_level(it.vref_low);
    if (!comp_flags_q[CF_INT_POS]) return 0;
    if (ref_flags_q[RF_VREF_DIR]) begin
      level = vh;
      return 1;
    end
    if (!ref_flags_q[RF_LADDER_EN]) return 0;
    if (ref_flags_q[RF_FROM_VREF]) begin
      if (vh < vl) return 0;
      src = vh - vl;
    end else begin
      src = trim_level(it.avdd_level);
    end
    if (ref_flags_q[RF_LOW_RANGE]) level = src * int'(tap_q) / 24;
    else level = src * (8 + int'(tap_q)) / 32;
    return 1;
  endfunction

  // Band-gap or VREF+ on the negative side
  function automatic bit negative_ref(acdf_in_t it, output int unsigned level);
    level = 0;
    if (neg_sel_q != NEG_INTERNAL) return 0;
    case (bg_sel_q)
      BG_1200: level = 1200;
      BG_600:  level = 600;
      BG_200:  level = 200;
      default: begin
        if (ref_flags_q[RF_FROM_VREF]) return 0;
        level = trim_level(it.vref_high);
      end
    endcase
    return 1;
  endfunction

  function automatic bit setup_ok(acdf_in_t it);
    int unsigned d;
    if (!comp_flags_q[CF_ENABLE]) return 0;
    if (comp_flags_q[CF_INT_POS] && !positive_ref(it, d)) return 0;
    return (neg_sel_q != NEG_INTERNAL) || negative_ref(it, d);
  endfunction

  function automatic bit edge_hit(logic prev, logic cur);
    bit rise, fall;
    rise = !prev && cur;
    fall = prev && !cur;
    case (edge_sel_q)
      EDGE_BOTH: return rise || fall;
      EDGE_RISE: return rise;
      EDGE_FALL: return fall;
      default:   return 0;
    endcase
  endfunction

  function automatic void publish(logic cur);
    logic prev;
    prev = published_q;
    if (!prev && cur) rise_now = 1'b1;
    published_q = cur;
    if (!latched_q && edge_hit(prev, cur)) begin
      latched_q = 1'b1;
      event_now = 1'b1;
    end
  endfunction

  function automatic bit gate_or(bit s, int act, int inact);
    return (mask_q[act] && s) || (mask_q[inact] && !s);
  endfunction

  function automatic bit gate_and(bit s, int act, int inact, bit r);
    if (mask_q[act]) r = r && s;
    if (mask_q[inact]) r = r && !s;
    return r;
  endfunction

  // OR terms, then the AND product qualified by the true/false enables
  function automatic bit blank_active(acdf_in_t it);
    bit hit, prod;
    hit = gate_or(it.blank_source_a, MC_OR_A_ACT, MC_OR_A_INACT) ||
          gate_or(it.blank_source_b, MC_OR_B_ACT, MC_OR_B_INACT) ||
          gate_or(it.blank_source_c, MC_OR_C_ACT, MC_OR_C_INACT);
    prod = 1'b1;
    prod = gate_and(it.blank_source_a, MC_AND_A_ACT, MC_AND_A_INACT, prod);
    prod = gate_and(it.blank_source_b, MC_AND_B_ACT, MC_AND_B_INACT, prod);
    prod = gate_and(it.blank_source_c, MC_AND_C_ACT, MC_AND_C_INACT, prod);
    if (mask_q[MC_AND_TRUE] && prod) hit = 1'b1;
    if (mask_q[MC_AND_FALSE] && !prod) hit = 1'b1;
    return hit;
  endfunction

  // One filter sample: three agreeing samples publish a change
  function automatic void filter_sample();
    if (raw_q == published_q) begin
      agree_cnt = '0;
      publish(published_q);
      return;
    end
    if (agree_cnt == 0 || raw_q != candidate_q) begin
      agree_cnt = 2'd1;
      candidate_q = raw_q;
      return;
    end
    agree_cnt = agree_cnt + 2'd1;
    if (agree_cnt >= MATCH_PUBLISH) begin
      agree_cnt = '0;
      publish(raw_q);
    end
  endfunction

  function automatic acdf_out_t predict(acdf_in_t it);
    acdf_out_t res;
    int unsigned p, n, span, acc;
    bit sup, stopped, active, filt_on, hi;
    sup = setup_ok(it);
    stopped = it.in_idle && comp_flags_q[CF_STOP_IDL];
    active = sup && !stopped;
    filt_on = comp_flags_q[CF_FILTER];
    event_now = 1'b0;
    rise_now = 1'b0;
    case (it.operation)
      OP_EVAL: begin
        if (!sup) begin
          published_q = 1'b0;
          raw_q = 1'b0;
          agree_cnt = '0;
        end else if (active) begin
          if (!positive_ref(it, p)) p = trim_level(it.positive_input);
          if (!negative_ref(it, n)) n = trim_level(it.negative_input);
          hi = p > n;
          if (comp_flags_q[CF_INVERT]) hi = !hi;
          if (blank_active(it)) hi = mask_q[MC_FORCE_LVL];
          raw_q = hi;
          if (!filt_on) begin
            agree_cnt = '0;
            publish(raw_q);
          end
        end
      end
      OP_TICK: begin
        if (active && filt_on) begin
          span = 32'd1 << div_exp_q;
          acc = 32'(tick_cnt) + 1;
          if (acc >= span) begin
            tick_cnt = '0;
            filter_sample();
          end else begin
            tick_cnt = 7'(acc);
          end
        end
      end
      OP_CLEAR: latched_q = 1'b0;
      default: ;
    endcase
    res.filtered_output = published_q;
    res.raw_output = raw_q;
    res.event_flag = latched_q;
    res.event_pulse = event_now;
    res.rising_pulse = rise_now;
    res.comparator_active = active;
    return res;
  endfunction

  // Register write; a change of enable, filter enable or divider restarts the filter
  function automatic void apply_write(logic [2:0] idx, logic [31:0] data);
    logic [15:0] v;
    v = data[15:0];
    case (idx)
      REG_COMP_FLAGS: begin
        if (v[CF_ENABLE] != comp_flags_q[CF_ENABLE] ||
            v[CF_FILTER] != comp_flags_q[CF_FILTER]) begin
          tick_cnt = '0;
          agree_cnt = '0;
        end
        comp_flags_q = v[4:0];
      end
      REG_NEG_SELECT: neg_sel_q = v[1:0];
      REG_EVENT_EDGE: edge_sel_q = v[1:0];
      REG_REF_TAP:    tap_q = v[3:0];
      REG_REF_FLAGS:  ref_flags_q = v[3:0];
      REG_BG_SELECT:  bg_sel_q = v[1:0];
      REG_MASK_CTRL:  mask_q = v;
      REG_FILTER_EXP: begin
        if (v[2:0] != div_exp_q) begin
          tick_cnt = '0;
          agree_cnt = '0;
        end
        div_exp_q = v[2:0];
      end
      default: ;
    endcase
  endfunction

  function automatic logic [31:0] reg_value(logic [2:0] idx);
    case (idx)
      REG_COMP_FLAGS: return 32'(comp_flags_q);
      REG_NEG_SELECT: return 32'(neg_sel_q);
      REG_EVENT_EDGE: return 32'(edge_sel_q);
      REG_REF_TAP:    return 32'(tap_q);
      REG_REF_FLAGS:  return 32'(ref_flags_q);
      REG_BG_SELECT:  return 32'(bg_sel_q);
      REG_MASK_CTRL:  return 32'(mask_q);
      default:        return 32'(div_exp_q);
    endcase
  endfunction

  function automatic int check_field(string name, logic want, logic got);
    if (got !== want) begin
      $error("%s: expected %0b, actual %0b", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  // Results are checked before the same edge's input transfer is queued
  always @(posedge clk) begin
    acdf_out_t want;
    if (!rst_n) begin
      comp_flags_q = '0; neg_sel_q = '0; edge_sel_q = '0; tap_q = '0;
      ref_flags_q = '0; bg_sel_q = '0; mask_q = '0; div_exp_q = '0;
      raw_q = 1'b0; published_q = 1'b0; candidate_q = 1'b0; latched_q = 1'b0;
      agree_cnt = '0; tick_cnt = '0;
      status_queue.delete();
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        n_results++;
        if (status_queue.size() == 0) begin
          $error("out_bus: result transfer with no item outstanding");
          errs++;
        end else begin
          want = status_queue.pop_front();
          errs += check_field("filtered_output", want.filtered_output,
                              out_bus.payload.filtered_output);
          errs += check_field("raw_output", want.raw_output, out_bus.payload.raw_output);
          errs += check_field("event_flag", want.event_flag, out_bus.payload.event_flag);
          errs += check_field("event_pulse", want.event_pulse, out_bus.payload.event_pulse);
          errs += check_field("rising_pulse", want.rising_pulse,
                              out_bus.payload.rising_pulse);
          errs += check_field("comparator_active", want.comparator_active,
                              out_bus.payload.comparator_active);
        end
      end
      if (in_bus.valid && in_bus.ready) begin
        status_queue.push_back(predict(in_bus.payload));
        n_items++;
        n_events += int'(event_now);
        n_rises += int'(rise_now);
      end
      if (psel && penable && pready) begin
        if (pwrite) begin
          apply_write(paddr[4:2], pwdata);
        end else if (prdata !== reg_value(paddr[4:2])) begin
          $error("prdata (reg %0d): expected %0h, actual %0h",
                 paddr[4:2], reg_value(paddr[4:2]), prdata);
          errs++;
        end
      end
    end
    mismatches <= errs;
    outstanding <= status_queue.size();
    items_seen <= n_items;
    results_seen <= n_results;
    events_seen <= n_events;
    rises_seen <= n_rises;
  end

endmodule

// ----- sim/analog_comparator_digital_filter_unit_tb.sv -----
// Testbench top: clock, reset, register setups, item stimulus and the final verdict.
`timescale 1ns / 1ps

module analog_comparator_digital_filter_unit_tb;
  import acdf_pkg::*;

  localparam int NUM_PHASES = 12;
  localparam int PHASE_ITEMS = 125;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int DRAIN_CYCLES = 8;
  // Operation code the block does not define
  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  acdf_in_if  in_bus ();
  acdf_out_if out_bus ();

  int mismatches, outstanding, items_seen, results_seen, events_seen, rises_seen;
  int cycle_count;
  int setups = 0;
  int stall_left = 0;
  bit gaps_on = 0;
  bit stalls_on = 0;

  // Setup copy used only to aim levels at the compare threshold
  logic [4:0]  cf_s;
  logic [3:0]  rf_s;
  int unsigned tap_s;

  // Current analog scene
  logic [15:0] lv_pos, lv_neg, lv_vh, lv_vl, lv_avdd;
  logic [2:0]  blanks_s;
  logic        idle_s;

  analog_comparator_digital_filter_unit dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_bus),
    .out_ch  (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  comparator_filter_checker checker_i (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_bus       (in_bus),
    .out_bus      (out_bus),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .mismatches   (mismatches),
    .outstanding  (outstanding),
    .items_seen   (items_seen),
    .results_seen (results_seen),
    .events_seen  (events_seen),
    .rises_seen   (rises_seen)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Mostly short pauses, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [15:0] pick_extreme();
    case ($urandom_range(0, 3))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h0001;
      default: return 16'hFFFE;
    endcase
  endfunction

  function automatic logic [15:0] near(int unsigned aim);
    int t;
    t = int'(aim) + int'($urandom_range(0, 2)) - 1;
    if (t < 0) t = 0;
    if (t > 65535) t = 65535;
    return 16'(t);
  endfunction

  // Rough ladder output, only to land the negative level on the threshold
  function automatic int unsigned ladder_aim();
    int unsigned src;
    if (rf_s[RF_VREF_DIR]) return 32'(lv_vh);
    if (rf_s[RF_FROM_VREF]) src = (lv_vh >= lv_vl) ? 32'(lv_vh) - 32'(lv_vl) : 0;
    else src = 32'(lv_avdd);
    if (rf_s[RF_LOW_RANGE]) return src * tap_s / 24;
    return src * (8 + tap_s) / 32;
  endfunction

  // Output side back-pressure
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_bus.ready <= 1'b0;
    end else if (stalls_on && $urandom_range(0, 4) == 0) begin
      stall_left <= pick_gap();
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= 1'b1;
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("analog_comparator_digital_filter_unit: mismatch");
    $finish;
  end

  // APB write: setup phase, access phase, then psel drops for an idle phase
  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic cfg_read(input logic [2:0] idx);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [4:0] cf, input logic [1:0] ns, input logic [1:0] ee,
                            input logic [3:0] tap, input logic [3:0] rf,
                            input logic [1:0] bg, input logic [15:0] mc,
                            input logic [2:0] fexp);
    cf_s = cf;
    rf_s = rf;
    tap_s = 32'(tap);
    setups++;
    cfg_write(REG_COMP_FLAGS, 32'(cf));
    cfg_write(REG_NEG_SELECT, 32'(ns));
    cfg_write(REG_EVENT_EDGE, 32'(ee));
    cfg_write(REG_REF_TAP, 32'(tap));
    cfg_write(REG_REF_FLAGS, 32'(rf));
    cfg_write(REG_BG_SELECT, 32'(bg));
    cfg_write(REG_MASK_CTRL, 32'(mc));
    cfg_write(REG_FILTER_EXP, 32'(fexp));
    for (int r = 0; r < 8; r++) cfg_read(3'(r));
  endtask

  task automatic random_config();
    logic [4:0]  cf;
    logic [15:0] mc;
    logic [2:0]  fexp;
    cf = 5'($urandom);
    if ($urandom_range(0, 7) != 0) cf[CF_ENABLE] = 1'b1;
    case ($urandom_range(0, 2))
      0: mc = '0;
      1: begin
        mc = '0;
        mc[$urandom_range(0, 15)] = 1'b1;
        mc[MC_FORCE_LVL] = 1'($urandom_range(0, 1));
      end
      default: mc = 16'($urandom);
    endcase
    fexp = ($urandom_range(0, 3) != 0) ? 3'($urandom_range(0, 2)) : 3'($urandom_range(0, 7));
    set_config(cf, 2'($urandom), 2'($urandom), 4'($urandom), 4'($urandom),
               2'($urandom), mc, fexp);
  endtask

  // One item transfer; valid stays high when the next item follows at once
  task automatic send_op(input logic [1:0] op, input logic [15:0] pos, input logic [15:0] neg,
                         input logic [15:0] vh, input logic [15:0] vl,
                         input logic [15:0] avdd, input logic [2:0] blanks,
                         input logic idle);
    acdf_in_t it;
    int gap;
    it.operation = op;
    it.positive_input = pos;
    it.negative_input = neg;
    it.vref_high = vh;
    it.vref_low = vl;
    it.avdd_level = avdd;
    it.blank_source_a = blanks[0];
    it.blank_source_b = blanks[1];
    it.blank_source_c = blanks[2];
    it.in_idle = idle;
    gap = gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.payload <= it;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
  endtask

  // Wait until every result is back, then let the pipeline drain
  task automatic settle();
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // New analog scene, often aimed at a compare threshold
  task automatic roll_levels();
    lv_pos = 16'($urandom);
    lv_neg = 16'($urandom);
    lv_vh = 16'($urandom);
    lv_vl = 16'($urandom);
    lv_avdd = 16'($urandom);
    case ($urandom_range(0, 3))
      1: begin
        lv_pos = pick_extreme();
        lv_neg = pick_extreme();
        lv_vh = pick_extreme();
        lv_vl = pick_extreme();
        lv_avdd = pick_extreme();
      end
      2: lv_neg = near(cf_s[CF_INT_POS] ? ladder_aim() : 32'(lv_pos));
      3: begin
        case ($urandom_range(0, 3))
          0: lv_pos = near(1200);
          1: lv_pos = near(600);
          2: lv_pos = near(200);
          default: lv_pos = near(32'(lv_vh));
        endcase
      end
      default: ;
    endcase
    blanks_s = 3'($urandom);
    idle_s = ($urandom_range(0, 7) == 0);
  endtask

  initial begin
    logic [1:0] op;
    int r;
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_bus.valid = 1'b0;
    in_bus.payload = '0;
    cf_s = '0;
    rf_s = '0;
    tap_s = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: disabled after reset
    send_op(OP_EVAL, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 3'b111, 1'b1);
    send_op(OP_TICK, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 3'b000, 1'b0);
    in_bus.valid <= 1'b0;
    settle();

    // Direct external compare, both edges, extremes and the equal case
    set_config(5'd1 << CF_ENABLE, 2'd0, EDGE_BOTH, 4'd0, 4'd0, BG_1200, 16'd0, 3'd0);
    send_op(OP_EVAL, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 3'b000, 1'b0);
    send_op(OP_EVAL, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 3'b000, 1'b0);
    send_op(OP_CLEAR, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 3'b000, 1'b0);
    send_op(OP_EVAL, 16'h8000, 16'h8000, 16'h0000, 16'h0000, 16'h0000, 3'b000, 1'b0);
    send_op(OP_EVAL, 16'h8001, 16'h8000, 16'h0000, 16'h0000, 16'h0000, 3'b000, 1'b0);
    send_op(OP_UNUSED, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 3'b000, 1'b0);
    send_op(OP_TICK, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 3'b000, 1'b0);
    in_bus.valid <= 1'b0;
    settle();

    // Inversion, stop in idle, OR blanking on A and an AND product of B and not C
    set_config((5'd1 << CF_ENABLE) | (5'd1 << CF_INVERT) | (5'd1 << CF_STOP_IDL), 2'd1,
               EDGE_FALL, 4'd0, 4'd0, BG_1200,
               (16'd1 << MC_OR_A_ACT) | (16'd1 << MC_AND_B_ACT) |
               (16'd1 << MC_AND_C_INACT) | (16'd1 << MC_AND_TRUE), 3'd0);
    send_op(OP_EVAL, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 3'b000, 1'b1);
    send_op(OP_EVAL, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 3'b000, 1'b0);
    send_op(OP_CLEAR, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 3'b000, 1'b0);
    send_op(OP_EVAL, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 3'b001, 1'b0);
    send_op(OP_EVAL, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 3'b010, 1'b0);
    send_op(OP_EVAL, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 3'b110, 1'b0);
    in_bus.valid <= 1'b0;
    settle();

    // Low-range ladder at top tap against VREF+ on the negative side, on the threshold
    set_config((5'd1 << CF_ENABLE) | (5'd1 << CF_INT_POS), NEG_INTERNAL, EDGE_BOTH, 4'd15,
               (4'd1 << RF_LADDER_EN) | (4'd1 << RF_LOW_RANGE), BG_VREF, 16'd0, 3'd0);
    send_op(OP_EVAL, 16'h0000, 16'h0000, 16'h9FFF, 16'h0000, 16'hFFFF, 3'b000, 1'b0);
    send_op(OP_EVAL, 16'h0000, 16'h0000, 16'h9FFE, 16'h0000, 16'hFFFF, 3'b000, 1'b0);
    in_bus.valid <= 1'b0;
    settle();

    // Ladder fed by the VREF pins: inverted pins are unsupported
    set_config((5'd1 << CF_ENABLE) | (5'd1 << CF_INT_POS), 2'd0, EDGE_BOTH, 4'd0,
               (4'd1 << RF_LADDER_EN) | (4'd1 << RF_FROM_VREF), BG_1200, 16'd0, 3'd0);
    send_op(OP_EVAL, 16'h0000, 16'h0000, 16'h1000, 16'h2000, 16'h0000, 3'b000, 1'b0);
    send_op(OP_EVAL, 16'h0000, 16'h0064, 16'h2000, 16'h1000, 16'h0000, 3'b000, 1'b0);
    in_bus.valid <= 1'b0;
    settle();

    // Internal VREF+ on the negative side while the ladder uses the pins
    set_config((5'd1 << CF_ENABLE) | (5'd1 << CF_INT_POS), NEG_INTERNAL, EDGE_BOTH, 4'd0,
               (4'd1 << RF_VREF_DIR) | (4'd1 << RF_FROM_VREF), BG_VREF, 16'd0, 3'd0);
    send_op(OP_EVAL, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 3'b000, 1'b0);
    in_bus.valid <= 1'b0;
    settle();

    // Filter without division: three agreeing samples publish
    set_config((5'd1 << CF_ENABLE) | (5'd1 << CF_FILTER), 2'd0, EDGE_RISE, 4'd0, 4'd0,
               BG_1200, 16'd0, 3'd0);
    send_op(OP_EVAL, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 3'b000, 1'b0);
    repeat (3) send_op(OP_TICK, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 3'b000, 1'b0);
    send_op(OP_EVAL, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 3'b000, 1'b0);
    repeat (3) send_op(OP_TICK, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 3'b000, 1'b0);
    in_bus.valid <= 1'b0;
    settle();

    // Random phases: all-ones setup, all-zero setup, then random setups
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph == 0) set_config('1, '1, '1, '1, '1, '1, '1, '1);
      else if (ph == 1) set_config('0, '0, '0, '0, '0, '0, '0, '0);
      else random_config();
      gaps_on = ($urandom_range(0, 3) != 0);
      stalls_on = ($urandom_range(0, 3) != 0);
      roll_levels();
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 4) == 0) roll_levels();
        else if ($urandom_range(0, 5) == 0) blanks_s = 3'($urandom);
        r = $urandom_range(0, 99);
        if (r < 45) op = OP_EVAL;
        else if (r < 88) op = OP_TICK;
        else if (r < 96) op = OP_CLEAR;
        else op = OP_UNUSED;
        send_op(op, lv_pos, lv_neg, lv_vh, lv_vl, lv_avdd, blanks_s, idle_s);
      end
      in_bus.valid <= 1'b0;
      settle();
    end

    $display("Covered %0d items and %0d results over %0d register setups,",
             items_seen, results_seen, setups);
    $display("with %0d event flags raised and %0d rising edges published.",
             events_seen, rises_seen);
    if (mismatches == 0) begin
      $display("analog_comparator_digital_filter_unit: match");
    end else begin
      $display("analog_comparator_digital_filter_unit: mismatch");
    end
    $finish;
  end

endmodule
